// ===== design/spq_pkg.sv =====
// Shared constants for the scale pitch quantiser.
package spq_pkg;

    localparam int MAX_INTERVALS_DEF = 256;
    localparam int PITCH_WIDTH_DEF   = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OCT_LEN        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MODE     = 2'd2;

    localparam logic [15:0] OCT_LEN_RST        = 16'd12;
    localparam logic [7:0]  INTERVAL_COUNT_RST = 8'd12;
    localparam logic [7:0]  SCALE_MODE_RST     = 8'd1;

    localparam logic [7:0]  COUNT_LIMIT = 8'd255;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

endpackage

// ===== design/spq_ram.sv =====
// Generic single-port RAM with registered read.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== design/spq_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
module spq_divider #(
    parameter int PITCH_WIDTH = spq_pkg::PITCH_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [PITCH_WIDTH-1:0] dividend,
    input  logic [15:0]            divisor,
    output logic                   done,
    output logic [PITCH_WIDTH-1:0] quotient,
    output logic [15:0]            remainder
);

    localparam int CW = $clog2(PITCH_WIDTH + 1);

    logic [PITCH_WIDTH-1:0] quo_reg, quo_next;
    logic [16:0]            rem_reg, rem_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [16:0]            trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], quo_reg[PITCH_WIDTH-1]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CW'(PITCH_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = trial - {1'b0, divisor};
                quo_next = {quo_reg[PITCH_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[PITCH_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[15:0];

endmodule

// ===== design/scale_pitch_quantizer_unit.sv =====
// Scale pitch quantiser: top level with sequencer, config registers and interval store.
// Write transfer: stores the interval if its index is in range, then gives the result. Map transfer:
// a validation walk over interval_count entries, the serial divider, a walk over the degrees,
// then multiply and sum. One transfer at a time; s_tready is high only when idle.
// Reset (synchronous, aresetn low): sequencer idle, no result pending, registers to
// octave length 12, interval count 12, scale mode 1; interval store is not cleared.
module scale_pitch_quantizer_unit #(
    parameter int MAX_INTERVALS = spq_pkg::MAX_INTERVALS_DEF,
    parameter int PITCH_WIDTH   = spq_pkg::PITCH_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // interval_index[7:0], interval_steps[15:8], pitch_in[47:16], round_up[48], zero pad
    input  logic [spq_pkg::S_TDATA_W-1:0]    s_tdata,
    // command[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // mapped_pitch[31:0], status[33:32], zero pad
    output logic [spq_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_we,
    input  logic [spq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int OW = PITCH_WIDTH + 18;
    localparam logic [8:0]  MAXI = 9'(MAX_INTERVALS);
    localparam logic signed [63:0] PMAX = (64'sd1 <<< (PITCH_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] PMIN = -PMAX - 64'sd1;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_VAL_RD   = 9'b000000010,
        ST_VAL_ADD  = 9'b000000100,
        ST_DIV      = 9'b000001000,
        ST_WALK     = 9'b000010000,
        ST_WALK_ADD = 9'b000100000,
        ST_MUL      = 9'b001000000,
        ST_SUM      = 9'b010000000,
        ST_OUT      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] tuning_reg;
    logic [7:0]  count_reg;
    logic [7:0]  mode_reg;

    logic [7:0]  k_reg, k_next;
    logic [16:0] sum_reg, sum_next;
    logic        up_reg, up_next;
    logic        neg_reg, neg_next;
    logic [PITCH_WIDTH-1:0] mag_reg, mag_next;
    logic signed [PITCH_WIDTH:0] oct_reg, oct_next;
    logic [15:0] rem_reg, rem_next;
    logic [16:0] deg_reg, deg_next;
    logic [16:0] prev_reg, prev_next;
    logic [7:0]  widx_reg, widx_next;
    logic signed [OW-1:0] off_reg, off_next;
    logic [31:0] res_reg, res_next;
    logic [1:0]  st_reg, st_next;
    logic        mvalid_reg, mvalid_next;
    logic [31:0] mpitch_reg, mpitch_next;
    logic [1:0]  mstatus_reg, mstatus_next;

    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]  ram_rdata;
    logic        div_start;
    logic        div_done;
    logic [PITCH_WIDTH-1:0] div_quo;
    logic [15:0] div_rem;

    logic        accept;
    logic [7:0]  in_idx;
    logic [7:0]  in_steps;
    logic [PITCH_WIDTH-1:0] in_pitch;
    logic        in_up;
    logic        static_bad;
    logic signed [63:0] off64;
    logic signed [63:0] total64;
    logic signed [OW-1:0] oct_ext;
    logic signed [OW-1:0] len_ext;

    assign in_idx   = s_tdata[7:0];
    assign in_steps = s_tdata[15:8];
    assign in_pitch = s_tdata[16 +: PITCH_WIDTH];
    assign in_up    = s_tdata[48];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign static_bad = (tuning_reg == 16'd0) || ($signed({48'd0, tuning_reg}) > PMAX) ||
                        (count_reg == 8'd0) || (count_reg > spq_pkg::COUNT_LIMIT) ||
                        ({1'b0, count_reg} > MAXI) ||
                        (mode_reg == 8'd0) || (mode_reg > count_reg);

    assign off64   = {{(64-OW){off_reg[OW-1]}}, off_reg};
    assign total64 = off64 + $signed({47'd0, deg_reg});
    assign oct_ext = {{(OW-PITCH_WIDTH-1){oct_reg[PITCH_WIDTH]}}, oct_reg};
    assign len_ext = {{(OW-16){1'b0}}, tuning_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tuning_reg <= spq_pkg::OCT_LEN_RST;
            count_reg  <= spq_pkg::INTERVAL_COUNT_RST;
            mode_reg   <= spq_pkg::SCALE_MODE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                spq_pkg::CFG_OCT_LEN:        tuning_reg <= cfg_data;
                spq_pkg::CFG_INTERVAL_COUNT: count_reg  <= cfg_data[7:0];
                spq_pkg::CFG_SCALE_MODE:     mode_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        sum_next     = sum_reg;
        up_next      = up_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        oct_next     = oct_reg;
        rem_next     = rem_reg;
        deg_next     = deg_reg;
        prev_next    = prev_reg;
        widx_next    = widx_reg;
        off_next     = off_reg;
        res_next     = res_reg;
        st_next      = st_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mpitch_next  = mpitch_reg;
        mstatus_next = mstatus_reg;
        ram_we       = 1'b0;
        ram_addr     = in_idx[AW-1:0];
        div_start    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next = '0;
                    st_next  = spq_pkg::STATUS_OK;
                    up_next  = in_up;
                    neg_next = in_pitch[PITCH_WIDTH-1];
                    mag_next = in_pitch[PITCH_WIDTH-1] ? (~in_pitch + 1'b1) : in_pitch;
                    k_next   = '0;
                    sum_next = '0;
                    if (s_tuser == spq_pkg::CMD_WRITE) begin
                        ram_we     = ({1'b0, in_idx} < MAXI);
                        state_next = ST_OUT;
                    end else if (static_bad) begin
                        st_next    = spq_pkg::STATUS_INVALID;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_VAL_RD;
                    end
                end
            end
            ST_VAL_RD: begin
                ram_addr   = k_reg[AW-1:0];
                state_next = ST_VAL_ADD;
            end
            ST_VAL_ADD: begin
                ram_addr = k_reg[AW-1:0];
                sum_next = sum_reg + {9'd0, ram_rdata};
                k_next   = k_reg + 8'd1;
                if (ram_rdata == 8'd0) begin
                    st_next    = spq_pkg::STATUS_INVALID;
                    state_next = ST_OUT;
                end else if (k_next == count_reg) begin
                    if (sum_next != {1'b0, tuning_reg}) begin
                        st_next    = spq_pkg::STATUS_INVALID;
                        state_next = ST_OUT;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end else begin
                    state_next = ST_VAL_RD;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (neg_reg && div_rem != 16'd0) begin
                        oct_next = -$signed({1'b0, div_quo}) - 2'sd1;
                        rem_next = tuning_reg - div_rem;
                    end else begin
                        oct_next = neg_reg ? -$signed({1'b0, div_quo})
                                           : $signed({1'b0, div_quo});
                        rem_next = div_rem;
                    end
                    deg_next   = '0;
                    prev_next  = '0;
                    widx_next  = mode_reg - 8'd1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                ram_addr = widx_reg[AW-1:0];
                if (deg_reg >= {1'b0, rem_reg}) begin
                    if (deg_reg != {1'b0, rem_reg} && !up_reg) begin
                        deg_next = prev_reg;
                    end
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_WALK_ADD;
                end
            end
            ST_WALK_ADD: begin
                ram_addr   = widx_reg[AW-1:0];
                prev_next  = deg_reg;
                deg_next   = deg_reg + {9'd0, ram_rdata};
                widx_next  = (widx_reg + 8'd1 == count_reg) ? 8'd0 : widx_reg + 8'd1;
                state_next = ST_WALK;
            end
            ST_MUL: begin
                off_next   = oct_ext * len_ext;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (off64 > PMAX || off64 < PMIN || total64 > PMAX || total64 < PMIN) begin
                    st_next = spq_pkg::STATUS_OVERFLOW;
                end else begin
                    res_next = total64[31:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next  = 1'b1;
                    mpitch_next  = (st_reg == spq_pkg::STATUS_OK) ? res_reg : 32'd0;
                    mstatus_next = st_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
        k_reg       <= k_next;
        sum_reg     <= sum_next;
        up_reg      <= up_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        oct_reg     <= oct_next;
        rem_reg     <= rem_next;
        deg_reg     <= deg_next;
        prev_reg    <= prev_next;
        widx_reg    <= widx_next;
        off_reg     <= off_next;
        res_reg     <= res_next;
        st_reg      <= st_next;
        mpitch_reg  <= mpitch_next;
        mstatus_reg <= mstatus_next;
    end

    spq_ram #(
        .WIDTH (8),
        .DEPTH (MAX_INTERVALS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_steps),
        .rdata (ram_rdata)
    );

    spq_divider #(
        .PITCH_WIDTH (PITCH_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (tuning_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {6'd0, mstatus_reg, mpitch_reg};

endmodule

// ===== design/spq_checker.sv =====
// Port-level checker for the scale pitch quantiser, bound to the top level.
module spq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [spq_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [spq_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           cfg_we,
    input logic [spq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [spq_pkg::CFG_DATA_W-1:0] cfg_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken while busy");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[33:32] != 2'd3)
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33:32] != spq_pkg::STATUS_OK |-> m_tdata[31:0] == 32'd0)
        else $error("non-zero pitch with error status");

endmodule

bind scale_pitch_quantizer_unit spq_checker u_spq_checker (.*);
